[src/saturating_fixed8_alu_unit_macros.svh]
// Assertion helpers used by the top-level RTL file of the fixed-point ALU.
`ifndef SATURATING_FIXED8_ALU_UNIT_MACROS_SVH
`define SATURATING_FIXED8_ALU_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfa assertion failed");

// Next-cycle implication, disabled while reset is low.
`define SFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfa assertion failed");

`endif

[src/sfa_pkg.sv]
package sfa_pkg;

    // Operation codes carried in s_axis_tuser
    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_SUB = 2'd1;
    localparam logic [1:0] CMD_MUL = 2'd2;
    localparam logic [1:0] CMD_DIV = 2'd3;

    localparam int DATA_W              = 8;
    localparam int FRAC_W              = 3;
    localparam logic [FRAC_W-1:0] FRAC_RESET = 3'd4;
    localparam int Q_BITS              = 8;
    localparam int DIV_STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES          = Q_BITS / DIV_STEPS_PER_STAGE;

    localparam logic signed [DATA_W-1:0] SAT_MAX = 8'sd127;
    localparam logic signed [DATA_W-1:0] SAT_MIN = -8'sd128;

    // Payload that travels down the pipeline
    typedef struct packed {
        logic [1:0]         cmd;
        logic               a_neg;
        logic               q_neg;
        logic               dz;
        logic               ovf;
        logic signed [15:0] val;
        logic [7:0]         bmag;
        logic [7:0]         rem;
        logic [7:0]         dlow;
        logic [7:0]         quo;
    } t_item;

endpackage

[src/sfa_div_stage.sv]
module sfa_div_stage
    import sfa_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_valid,
    output t_item o_item
);

    t_item n_item;
    t_item r_item;
    logic  r_valid;

    // Run restoring division steps on the partial remainder
    always_comb begin
        logic [8:0] trial;
        logic       qbit;
        n_item = i_item;
        for (int s = 0; s < DIV_STEPS_PER_STAGE; s++) begin
            trial = {n_item.rem, n_item.dlow[7]};
            if (trial >= {1'b0, n_item.bmag}) begin
                n_item.rem = 8'(trial - {1'b0, n_item.bmag});
                qbit       = 1'b1;
            end else begin
                n_item.rem = trial[7:0];
                qbit       = 1'b0;
            end
            n_item.quo  = {n_item.quo[6:0], qbit};
            n_item.dlow = {n_item.dlow[6:0], 1'b0};
        end
    end

    // Advance valid when the stage moves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Capture payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[src/saturating_fixed8_alu_unit.sv]
// Saturating signed 8-bit fixed-point ALU (add, subtract, multiply, divide) with a
// programmable number of fraction bits (i_cfg_wdata, reset 4; write it only while
// idle). Operands enter on s_axis (tdata, tuser = command), results leave on m_axis.
// One transaction is accepted every cycle unless back-pressure from m_axis_tready
// has filled the stages. The 8-bit quotient comes from a restoring divider that
// resolves two quotient bits per stage over four stages, between an operand-prep
// stage and a clamp/output stage. Stages with no valid data fill in even while the
// output is stalled. Division by zero returns 127 or -128 by the dividend's sign
// with the divide_by_zero flag set and saturated clear.
`include "saturating_fixed8_alu_unit_macros.svh"

module saturating_fixed8_alu_unit
    import sfa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] operand_a, [15:8] operand_b
    input  logic [1:0]  s_axis_tuser,   // [1:0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] result
    output logic [1:0]  m_axis_tuser    // [0] saturated, [1] divide_by_zero
);

    logic [FRAC_W-1:0] r_frac;

    // Stage A (prep) signals
    logic signed [7:0]  w_a;
    logic signed [7:0]  w_b;
    logic [7:0]         w_amag;
    logic [14:0]        w_dmag;
    logic [8:0]         w_sum;
    logic [8:0]         w_diff;
    logic signed [15:0] w_prod;
    t_item              n_a;
    t_item              r_a;
    logic               r_va;
    logic               w_en_a;

    // Divider chain
    t_item w_item  [0:DIV_STAGES];
    logic  w_valid [0:DIV_STAGES];
    logic  w_den   [0:DIV_STAGES];

    // Output stage
    logic              w_en_out;
    logic signed [7:0] n_res;
    logic              n_sat;
    logic              n_dz;
    logic signed [7:0] r_res;
    logic              r_sat;
    logic              r_dz;
    logic              r_vout;

    // Clamp a 16-bit exact value to the 8-bit range; bit 8 is the saturation flag
    function automatic logic [8:0] clamp16(input logic signed [15:0] v);
        logic [8:0] c;
        if (v > 16'(SAT_MAX)) begin
            c = {1'b1, SAT_MAX};
        end else if (v < 16'(SAT_MIN)) begin
            c = {1'b1, SAT_MIN};
        end else begin
            c = {1'b0, v[7:0]};
        end
        return c;
    endfunction

    // Hold the fraction-bit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac <= FRAC_RESET;
        end else if (i_cfg_we) begin
            r_frac <= i_cfg_wdata;
        end
    end

    // Stage enables: a stage moves when empty or when the next one moves
    assign w_en_out           = !r_vout || m_axis_tready;
    assign w_den[DIV_STAGES]  = w_en_out;
    assign w_en_a             = !r_va || w_den[0];
    assign s_axis_tready      = w_en_a;

    // Prepare operands, exact add/sub/mul and divider setup
    assign w_a    = $signed(s_axis_tdata[7:0]);
    assign w_b    = $signed(s_axis_tdata[15:8]);
    assign w_amag = w_a[7] ? 8'(-w_a) : w_a;
    assign w_dmag = 15'({7'b0, w_amag} << r_frac);
    assign w_sum  = {w_a[7], w_a} + {w_b[7], w_b};
    assign w_diff = {w_a[7], w_a} - {w_b[7], w_b};
    assign w_prod = w_a * w_b;

    always_comb begin
        n_a       = '0;
        n_a.cmd   = s_axis_tuser;
        n_a.a_neg = w_a[7];
        n_a.q_neg = w_a[7] ^ w_b[7];
        n_a.dz    = (s_axis_tuser == CMD_DIV) && (w_b == 8'sd0);
        n_a.bmag  = w_b[7] ? 8'(-w_b) : w_b;
        n_a.ovf   = {1'b0, w_dmag} >= {n_a.bmag, 8'b0};
        n_a.rem   = {1'b0, w_dmag[14:8]};
        n_a.dlow  = w_dmag[7:0];
        case (s_axis_tuser)
            CMD_ADD: n_a.val = {{7{w_sum[8]}}, w_sum};
            CMD_SUB: n_a.val = {{7{w_diff[8]}}, w_diff};
            CMD_MUL: n_a.val = w_prod;
            default: n_a.val = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (w_en_a) begin
            r_va <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_a) begin
            r_a <= n_a;
        end
    end

    assign w_item[0]  = r_a;
    assign w_valid[0] = r_va;

    // Divider stages, two quotient bits each
    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        assign w_den[g] = !w_valid[g+1] || w_den[g+1];

        sfa_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_den[g]),
            .i_valid (w_valid[g]),
            .i_item  (w_item[g]),
            .o_valid (w_valid[g+1]),
            .o_item  (w_item[g+1])
        );
    end

    // Select and clamp the final result
    always_comb begin
        t_item              it;
        logic signed [15:0] sh;
        logic [8:0]         c;
        it    = w_item[DIV_STAGES];
        sh    = it.val >>> r_frac;
        n_dz  = 1'b0;
        n_sat = 1'b0;
        n_res = '0;
        case (it.cmd)
            CMD_ADD, CMD_SUB: begin
                c     = clamp16(it.val);
                n_sat = c[8];
                n_res = $signed(c[7:0]);
            end
            CMD_MUL: begin
                c     = clamp16(sh);
                n_sat = c[8];
                n_res = $signed(c[7:0]);
            end
            default: begin
                c = '0;
                if (it.dz) begin
                    n_dz  = 1'b1;
                    n_res = it.a_neg ? SAT_MIN : SAT_MAX;
                end else if (it.ovf) begin
                    n_sat = 1'b1;
                    n_res = it.q_neg ? SAT_MIN : SAT_MAX;
                end else if (it.q_neg) begin
                    n_sat = it.quo > 8'd128;
                    n_res = n_sat ? SAT_MIN : 8'(-$signed({1'b0, it.quo}));
                end else begin
                    n_sat = it.quo > 8'd127;
                    n_res = n_sat ? SAT_MAX : $signed(it.quo);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vout <= 1'b0;
        end else if (w_en_out) begin
            r_vout <= w_valid[DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_out) begin
            r_res <= n_res;
            r_sat <= n_sat;
            r_dz  <= n_dz;
        end
    end

    assign m_axis_tvalid = r_vout;
    assign m_axis_tdata  = r_res;
    assign m_axis_tuser  = {r_dz, r_sat};

    // A clamped or divide-by-zero result is always one of the two extremes
    `SFA_ASSERT_IMP(a_sat_extreme, i_clk, i_rst_n,
        m_axis_tvalid && (m_axis_tuser[0] || m_axis_tuser[1]),
        m_axis_tdata == 8'h7f || m_axis_tdata == 8'h80)
    // Divide by zero never also reports overflow saturation
    `SFA_ASSERT_IMP(a_dz_no_sat, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tuser[1], !m_axis_tuser[0])
    // An accepted transaction lands in the prep stage
    `SFA_ASSERT_NEXT(a_accept_fill, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready && i_rst_n, r_va)
    // A full prep stage that cannot drain blocks the input
    `SFA_ASSERT_IMP(a_ready_block, i_clk, i_rst_n, r_va && !w_den[0], !s_axis_tready)

endmodule
